### hw/rtl/binary_pixel_digit_classifier_top_macros.svh
// Assertion macros used by the checker of the classifier.
`ifndef BINARY_PIXEL_DIGIT_CLASSIFIER_TOP_MACROS_SVH
`define BINARY_PIXEL_DIGIT_CLASSIFIER_TOP_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define BPDC_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define BPDC_ASSERT_CLK(lbl, prop, msg) \
	`BPDC_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

### hw/rtl/bpdc_pkg.sv
package bpdc_pkg;

	localparam int unsigned PIXELS_PER_IMAGE_DEF = 784;
	localparam int unsigned NUM_CLASSES_DEF      = 10;

	localparam int unsigned PIXEL_W  = 8;
	localparam int unsigned LABEL_W  = 4;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned SCORE_W  = 26;

	// Results that may be in flight or queued at the output at once.
	localparam int unsigned FIFO_DEPTH = 8;

	localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd230;
	localparam logic [SCORE_W-1:0] SCORE_MAX       = '1;

	localparam logic ACTION_TRAIN    = 1'b0;
	localparam logic ACTION_CLASSIFY = 1'b1;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [SCORE_W-1:0] best_score;
	} result_t;

endpackage

### hw/rtl/bpdc_pix_if.sv
interface bpdc_pix_if import bpdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [PIXEL_W-1:0] pixel;
	logic [LABEL_W-1:0] label;
	logic               last_pixel;

	modport source (output valid, action, pixel, label, last_pixel, input ready);
	modport sink (input valid, action, pixel, label, last_pixel, output ready);
endinterface

### hw/rtl/bpdc_res_if.sv
interface bpdc_res_if import bpdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [SCORE_W-1:0] best_score;

	modport source (output valid, digit, best_score, input ready);
	modport sink (input valid, digit, best_score, output ready);
endinterface

### hw/rtl/binary_pixel_digit_classifier_top.sv
// Throughput: one pixel item per cycle; each weight row is read on accept and
// written back in the next cycle. Ready drops only while FIFO_DEPTH results are
// in flight or queued. The last pixel of a classify image passes the stage
// register, each argmax tree level and the result queue before the result is offered.
// Reset: scores, position and queue clear and the threshold returns to 230; weights read
// as zero until first written (a fill count tracks this), with no clearing pass.
module binary_pixel_digit_classifier_top import bpdc_pkg::*; #(
	parameter int unsigned PIXELS_PER_IMAGE = PIXELS_PER_IMAGE_DEF,
	parameter int unsigned NUM_CLASSES      = NUM_CLASSES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	bpdc_pix_if.sink           pix_in,
	bpdc_res_if.source         res_out,
	input  logic               cfg_we,
	input  logic [PIXEL_W-1:0] cfg_wdata
);

	localparam int unsigned ADDR_W   = (PIXELS_PER_IMAGE > 1) ? $clog2(PIXELS_PER_IMAGE) : 1;
	localparam int unsigned POS_W    = $clog2(PIXELS_PER_IMAGE + 1);
	localparam int unsigned ROW_W    = NUM_CLASSES * WEIGHT_W;
	localparam int unsigned CREDIT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic               in_range;
		logic               on;
		logic               action;
		logic [LABEL_W-1:0] label;
		logic               last;
		logic [ADDR_W-1:0]  row;
	} pix_ctl_t;

	logic [PIXEL_W-1:0]                 thr_q;
	logic [POS_W-1:0]                   pos_q;
	logic [POS_W-1:0]                   fill_q;
	logic [CREDIT_W-1:0]                credit_q;
	logic                               vld_s1;
	pix_ctl_t                           ctl_s1;
	logic                               fwd_vld_q;
	logic [ADDR_W-1:0]                  fwd_addr_q;
	logic [ROW_W-1:0]                   fwd_row_q;
	logic [NUM_CLASSES-1:0][SCORE_W-1:0] sc_q;
	logic [NUM_CLASSES-1:0][SCORE_W-1:0] sc_next;

	logic             accept;
	logic             pos_in_range;
	logic             ram_we;
	logic [ROW_W-1:0] rd_row;
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] new_row;
	logic             fwd_hit;
	logic             row_known;
	logic             snap_valid;
	logic             res_inc;
	logic             res_pop;
	logic             tree_valid;
	result_t          tree_result;

	assign accept       = pix_in.valid && pix_in.ready;
	assign pix_in.ready = (credit_q < CREDIT_W'(FIFO_DEPTH));
	assign pos_in_range = (pos_q < POS_W'(PIXELS_PER_IMAGE));
	assign res_inc      = accept && pix_in.last_pixel && (pix_in.action == ACTION_CLASSIFY);
	assign res_pop      = res_out.valid && res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Position saturates at the image size and restarts after the last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			credit_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				if (pix_in.last_pixel) begin
					pos_q <= '0;
				end else if (pos_in_range) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (res_inc && !res_pop) begin
				credit_q <= credit_q + 1'b1;
			end else if (!res_inc && res_pop) begin
				credit_q <= credit_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.in_range <= pos_in_range;
			ctl_s1.on       <= pos_in_range && (pix_in.pixel > thr_q);
			ctl_s1.action   <= pix_in.action;
			ctl_s1.label    <= pix_in.label;
			ctl_s1.last     <= pix_in.last_pixel;
			ctl_s1.row      <= pos_q[ADDR_W-1:0];
		end
	end

	bpdc_weight_ram #(
		.DEPTH  (PIXELS_PER_IMAGE),
		.WIDTH  (ROW_W),
		.ADDR_W (ADDR_W)
	) u_weight_ram (
		.clk   (clk),
		.re    (accept && pos_in_range),
		.raddr (pos_q[ADDR_W-1:0]),
		.rdata (rd_row),
		.we    (ram_we),
		.waddr (ctl_s1.row),
		.wdata (new_row)
	);

	// Rows are first visited in ascending order, so every row below the fill
	// count has been written at least once and every row at or above it reads as zero.
	// The last written row is forwarded because the memory returns the old
	// row when the same row is read again in the cycle it is written.
	assign ram_we    = vld_s1 && ctl_s1.in_range;
	assign fwd_hit   = fwd_vld_q && (fwd_addr_q == ctl_s1.row);
	assign row_known = (POS_W'(ctl_s1.row) < fill_q);
	assign cur_row   = fwd_hit ? fwd_row_q : (row_known ? rd_row : '0);

	always_comb begin
		logic [WEIGHT_W-1:0] w;
		logic [SCORE_W:0]    sum;
		logic                upd;
		logic                add;
		new_row = cur_row;
		sc_next = sc_q;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			w   = cur_row[c*WEIGHT_W +: WEIGHT_W];
			upd = ctl_s1.on && (ctl_s1.action == ACTION_TRAIN) &&
				(ctl_s1.label == LABEL_W'(c));
			add = ctl_s1.on && (ctl_s1.action == ACTION_CLASSIFY);
			sum = {1'b0, sc_q[c]} + (SCORE_W+1)'(w);
			// Halfway towards one: (w + 1.0) / 2 in Q0.16.
			if (upd) begin
				new_row[c*WEIGHT_W +: WEIGHT_W] = {1'b1, w[WEIGHT_W-1:1]};
			end
			if (add) begin
				sc_next[c] = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			fwd_vld_q <= 1'b0;
			sc_q      <= '0;
		end else begin
			if (ram_we) begin
				fwd_vld_q <= 1'b1;
				if (POS_W'(ctl_s1.row) == fill_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (vld_s1) begin
				sc_q <= ctl_s1.last ? '0 : sc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_addr_q <= ctl_s1.row;
			fwd_row_q  <= new_row;
		end
	end

	assign snap_valid = vld_s1 && ctl_s1.last && (ctl_s1.action == ACTION_CLASSIFY);

	bpdc_argmax #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_argmax (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (snap_valid),
		.scores     (sc_next),
		.out_valid  (tree_valid),
		.out_result (tree_result)
	);

	bpdc_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tree_valid),
		.push_data (tree_result),
		.res_out   (res_out)
	);

endmodule

### hw/rtl/bpdc_weight_ram.sv
module bpdc_weight_ram import bpdc_pkg::*; #(
	parameter int unsigned DEPTH  = PIXELS_PER_IMAGE_DEF,
	parameter int unsigned WIDTH  = NUM_CLASSES_DEF * WEIGHT_W,
	parameter int unsigned ADDR_W = 10
) (
	input  logic              clk,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the row being written in the same cycle returns the old row.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/bpdc_argmax.sv
module bpdc_argmax import bpdc_pkg::*; #(
	parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [NUM_CLASSES-1:0][SCORE_W-1:0] scores,
	output logic                                out_valid,
	output result_t                             out_result
);

	localparam int unsigned LEVELS = $clog2(NUM_CLASSES);
	localparam int unsigned LEAVES = 1 << LEVELS;
	localparam int unsigned NODES  = 2 * LEAVES - 1;

	// Heap-ordered tree: node n has children 2n+1 and 2n+2, leaves at the end.
	// Every node is a register, so each tree level is one pipeline stage.
	logic [SCORE_W-1:0] sc_q  [NODES];
	logic [DIGIT_W-1:0] idx_q [NODES];
	logic [LEVELS:0]    vld_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < LEAVES; i++) begin
			if (i < NUM_CLASSES) begin
				sc_q[LEAVES-1+i] <= scores[i];
			end else begin
				sc_q[LEAVES-1+i] <= '0;
			end
			idx_q[LEAVES-1+i] <= DIGIT_W'(i);
		end
		// The left child always holds the lower classes, so it wins a tie.
		for (int n = 0; n < LEAVES - 1; n++) begin
			if (sc_q[2*n+2] > sc_q[2*n+1]) begin
				sc_q[n]  <= sc_q[2*n+2];
				idx_q[n] <= idx_q[2*n+2];
			end else begin
				sc_q[n]  <= sc_q[2*n+1];
				idx_q[n] <= idx_q[2*n+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LEVELS-1:0], in_valid};
		end
	end

	assign out_valid             = vld_q[LEVELS];
	assign out_result.digit      = idx_q[0];
	assign out_result.best_score = sc_q[0];

endmodule

### hw/rtl/bpdc_result_fifo.sv
module bpdc_result_fifo import bpdc_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  result_t           push_data,
	bpdc_res_if.source        res_out
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	result_t          mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign pop = res_out.valid && res_out.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign res_out.valid      = (cnt_q != '0);
	assign res_out.digit      = mem[rd_ptr_q].digit;
	assign res_out.best_score = mem[rd_ptr_q].best_score;

endmodule

### hw/rtl/bpdc_checker.sv
`include "binary_pixel_digit_classifier_top_macros.svh"

module bpdc_checker import bpdc_pkg::*; #(
	parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_action,
	input logic               in_last,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DIGIT_W-1:0] out_digit,
	input logic [SCORE_W-1:0] out_score
);

	localparam int unsigned PEND_W = $clog2(FIFO_DEPTH + 2);

	logic              req;
	logic              done;
	logic [PEND_W-1:0] pending_q;

	// Classify images whose last pixel went in and whose result is not yet out.
	assign req  = in_valid && in_ready && in_last && (in_action == ACTION_CLASSIFY);
	assign done = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req && !done) begin
			pending_q <= pending_q + 1'b1;
		end else if (!req && done) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`BPDC_ASSERT_CLK(a_digit_range, out_valid |-> ({1'b0, out_digit} < (DIGIT_W+1)'(NUM_CLASSES)), "digit out of range")
	`BPDC_ASSERT_CLK(a_no_spurious, done |-> (pending_q != '0), "result without a classify image")
	`BPDC_ASSERT_CLK(a_ready_bound, (pending_q >= PEND_W'(FIFO_DEPTH)) |-> !in_ready, "ready while queue full")
	`BPDC_ASSERT_CLK(a_valid_hold, (out_valid && !out_ready) |=> out_valid, "result valid dropped")
	`BPDC_ASSERT_CLK(a_payload_hold, (out_valid && !out_ready) |=> ($stable(out_digit) && $stable(out_score)), "stalled result changed")

endmodule

bind binary_pixel_digit_classifier_top bpdc_checker #(
	.NUM_CLASSES (NUM_CLASSES)
) u_bpdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.in_action (pix_in.action),
	.in_last   (pix_in.last_pixel),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_digit (res_out.digit),
	.out_score (res_out.best_score)
);

### test/binary_pixel_digit_classifier_top_tb.sv
module binary_pixel_digit_classifier_top_tb;
	import bpdc_pkg::*;

	localparam int unsigned NPIX = PIXELS_PER_IMAGE_DEF;
	localparam int unsigned NCLS = NUM_CLASSES_DEF;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned PHASE_ITEMS = 300;

	typedef struct packed {
		logic               action;
		logic [PIXEL_W-1:0] pixel;
		logic [LABEL_W-1:0] label;
		logic               last_pixel;
	} pixel_item_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [PIXEL_W-1:0] cfg_wdata;

	bpdc_pix_if pix ();
	bpdc_res_if res ();

	binary_pixel_digit_classifier_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix),
		.res_out   (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the classifier state.
	logic [WEIGHT_W-1:0] weight_mem [NPIX*NCLS];
	logic [SCORE_W-1:0]  class_score [NCLS];
	int unsigned         pix_pos;
	logic [PIXEL_W-1:0]  thr_model;

	pixel_item_t pixel_q [$];
	result_t     result_q [$];
	pixel_item_t drv_item;

	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Applies one accepted pixel to the shadow state; queues the winner on
	// the last pixel of a classify image.
	task automatic classify_pixel(input pixel_item_t it);
		int unsigned row;
		int unsigned idx;
		int unsigned best;
		logic [WEIGHT_W:0] wsum;
		logic [SCORE_W:0] ssum;
		result_t r;
		if (pix_pos < NPIX) begin
			row = pix_pos * NCLS;
			if (it.pixel > thr_model) begin
				if (it.action == ACTION_TRAIN) begin
					if (it.label < NCLS) begin
						idx = row + it.label;
						wsum = {1'b0, weight_mem[idx]} + (WEIGHT_W+1)'(1 << WEIGHT_W);
						weight_mem[idx] = wsum[WEIGHT_W:1];
					end
				end else begin
					for (int c = 0; c < NCLS; c++) begin
						ssum = {1'b0, class_score[c]} + weight_mem[row + c];
						class_score[c] = ssum[SCORE_W] ? SCORE_MAX : ssum[SCORE_W-1:0];
					end
				end
			end
			pix_pos++;
		end
		if (it.last_pixel) begin
			if (it.action == ACTION_CLASSIFY) begin
				best = 0;
				for (int c = 1; c < NCLS; c++)
					if (class_score[c] > class_score[best])
						best = c;
				r.digit = DIGIT_W'(best);
				r.best_score = class_score[best];
				result_q.push_back(r);
			end
			for (int c = 0; c < NCLS; c++)
				class_score[c] = '0;
			pix_pos = 0;
		end
	endtask

	task automatic push_pixel(input logic act, input logic [PIXEL_W-1:0] px,
			input logic [LABEL_W-1:0] lb, input logic last);
		pixel_item_t it;
		it.action = act;
		it.pixel = px;
		it.label = lb;
		it.last_pixel = last;
		pixel_q.push_back(it);
	endtask

	// Pixel values cluster on the extremes and right at the threshold.
	function automatic logic [PIXEL_W-1:0] rand_pixel();
		int unsigned t;
		case ($urandom_range(0, 9))
			0, 1: rand_pixel = '0;
			2, 3: rand_pixel = '1;
			4, 5: begin
				t = thr_model + $urandom_range(0, 1);
				rand_pixel = (t > 255) ? 8'd255 : PIXEL_W'(t);
			end
			default: rand_pixel = PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Most images keep one action, and train images one valid label, while classify images
	// draw a label per pixel; a few mix actions per pixel or carry labels beyond the last class.
	task automatic add_random_image(input int unsigned len);
		int unsigned kind;
		logic act;
		logic [LABEL_W-1:0] lb;
		kind = $urandom_range(0, 9);
		act = $urandom_range(0, 1);
		lb = (kind == 0) ? LABEL_W'($urandom_range(0, 15)) : LABEL_W'($urandom_range(0, 9));
		for (int unsigned i = 0; i < len; i++)
			push_pixel((kind == 1) ? logic'($urandom_range(0, 1)) : act, rand_pixel(),
				(act == ACTION_CLASSIFY) ? LABEL_W'($urandom_range(0, 15)) : lb,
				i == len - 1);
	endtask

	// Sampled at the falling edge, after the driver and the monitor have settled.
	task automatic wait_idle();
		while (pixel_q.size() != 0 || pix.valid || result_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [PIXEL_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_model = v;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.action <= ACTION_TRAIN;
			pix.pixel <= '0;
			pix.label <= '0;
			pix.last_pixel <= 1'b0;
		end else if (!pix.valid || pix.ready) begin
			if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				drv_item = pixel_q.pop_front();
				pix.valid <= 1'b1;
				pix.action <= drv_item.action;
				pix.pixel <= drv_item.pixel;
				pix.label <= drv_item.label;
				pix.last_pixel <= drv_item.last_pixel;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else
			res.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result digit %0d score %0d",
						res.digit, res.best_score));
				end else begin
					if (res.digit !== result_q[0].digit)
						report_mismatch($sformatf("digit %0d, want %0d",
							res.digit, result_q[0].digit));
					if (res.best_score !== result_q[0].best_score)
						report_mismatch($sformatf("best_score %0d, want %0d",
							res.best_score, result_q[0].best_score));
					void'(result_q.pop_front());
				end
			end
			if (pix.valid && pix.ready)
				classify_pixel('{pix.action, pix.pixel, pix.label, pix.last_pixel});
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("binary_pixel_digit_classifier_top verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned budget;
		int unsigned len;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix.valid = 1'b0;
		pix.action = ACTION_TRAIN;
		pix.pixel = '0;
		pix.label = '0;
		pix.last_pixel = 1'b0;
		res.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		for (int i = 0; i < NPIX*NCLS; i++)
			weight_mem[i] = '0;
		for (int c = 0; c < NCLS; c++)
			class_score[c] = '0;
		pix_pos = 0;
		thr_model = THRESHOLD_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, at the reset threshold. An empty classifier ties
		// every class at zero.
		push_pixel(ACTION_CLASSIFY, 8'd255, 4'd15, 1'b1);
		// Training at the threshold boundary, with labels beyond the last class.
		push_pixel(ACTION_TRAIN, 8'd255, 4'd9, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd231, 4'd0, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd230, 4'd1, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd0, 4'd15, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd255, 4'd10, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd255, 4'd3, 1'b1);
		// Three classes end level, so the lowest one wins.
		repeat (5) push_pixel(ACTION_CLASSIFY, 8'd255, 4'd0, 1'b0);
		push_pixel(ACTION_CLASSIFY, 8'd255, 4'd0, 1'b1);
		// Mixed actions within one image.
		push_pixel(ACTION_TRAIN, 8'd255, 4'd9, 1'b0);
		push_pixel(ACTION_CLASSIFY, 8'd255, 4'd5, 1'b0);
		push_pixel(ACTION_CLASSIFY, 8'd0, 4'd5, 1'b1);
		push_pixel(ACTION_CLASSIFY, 8'd255, 4'd6, 1'b1);
		// A train pixel closing a classify image gives no result.
		push_pixel(ACTION_CLASSIFY, 8'd255, 4'd0, 1'b0);
		push_pixel(ACTION_TRAIN, 8'd170, 4'd5, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_threshold(8'd0);
				1: set_threshold(8'd255);
				2: set_threshold(PIXEL_W'($urandom_range(1, 254)));
				default: set_threshold(PIXEL_W'($urandom_range(0, 255)));
			endcase
			src_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 25 : 0;
			snk_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 25 : 0;
			// One image runs past the image size, mixing actions and closing
			// on a classify pixel.
			if (ph == 2) begin
				len = NPIX + $urandom_range(1, 16);
				for (int unsigned i = 0; i < len; i++)
					push_pixel((i == len - 1) ? ACTION_CLASSIFY : logic'($urandom_range(0, 1)),
						rand_pixel(), LABEL_W'($urandom_range(0, 9)), i == len - 1);
			end
			budget = 0;
			while (budget < PHASE_ITEMS) begin
				len = $urandom_range(1, 24);
				add_random_image(len);
				budget += len;
			end
		end

		wait_idle();
		if (mismatches == 0 && result_q.size() == 0)
			$display("binary_pixel_digit_classifier_top verification clean");
		else
			$display("binary_pixel_digit_classifier_top verification failed");
		$finish;
	end

endmodule

### binary_pixel_digit_classifier_top.f
+incdir+hw/rtl
hw/rtl/bpdc_pkg.sv
hw/rtl/bpdc_pix_if.sv
hw/rtl/bpdc_res_if.sv
hw/rtl/bpdc_weight_ram.sv
hw/rtl/bpdc_argmax.sv
hw/rtl/bpdc_result_fifo.sv
hw/rtl/binary_pixel_digit_classifier_top.sv
hw/rtl/bpdc_checker.sv
test/binary_pixel_digit_classifier_top_tb.sv
